>>> src/frame_header_checker_top_assert.svh
// Assertion macros shared by the frame header checker RTL.
// Each macro expands to one labeled concurrent assertion.
`ifndef FRAME_HEADER_CHECKER_TOP_ASSERT_SVH
`define FRAME_HEADER_CHECKER_TOP_ASSERT_SVH

// Condition implies property in the same cycle.
`define FHC_ASSERT_SAME(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("fhc assertion failed");

// Condition implies property in the next cycle.
`define FHC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("fhc assertion failed");

`endif

>>> src/fhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhc_pkg
// Constants and codes of the frame header checker.
// ----------------------------------------------------------------------------
package fhc_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 40;
    localparam int HEADER_W     = HEADER_BYTES * 8;

    // Byte counter, saturating
    localparam int              COUNT_W   = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(HEADER_BYTES);

    // Configuration register indexes
    localparam int              CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAGIC = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_MAJOR = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEWEST_MINOR   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT  = 8'd3;

    // Error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd1;
    localparam logic [2:0] ERR_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ERR_VERSION    = 3'd3;
    localparam logic [2:0] ERR_RESERVED   = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd5;

    // Configuration reset values
    localparam logic [31:0] MAGIC_RESET = 32'h0000_0000;
    localparam logic [15:0] MAJOR_RESET = 16'd1;
    localparam logic [15:0] MINOR_RESET = 16'd0;
    localparam logic [63:0] LIMIT_RESET = {64{1'b1}};

endpackage

>>> src/frame_header_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_header_checker_top
// Assembles a 40-byte little-endian frame header from a byte stream and
// reports an error code with the decoded fields on the final byte.
// ----------------------------------------------------------------------------
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------
//  s_       | s_valid/s_ready, 2 fields    | one header byte per transfer
//  m_       | m_valid/m_ready, 8 fields    | one result per final byte
//  cfg_     | cfg_valid/cfg_ready          | index + data register write
//
// One byte is taken every cycle while s_ready is high; the snapshot register takes a
// final byte at its transfer edge, and the result is valid from the result register.
// Rate is set by the byte insert into the header register, one per cycle unstalled.
// Reset (aresetn low, synchronous) clears the byte counter and the valid flags
// and loads the configuration reset values. A stalled m_ side backs up through the
// snapshot stage into s_ready; cfg_ready is always high.
// ----------------------------------------------------------------------------
module frame_header_checker_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_final_byte,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_error_code,
    output logic [15:0]                       m_major_version,
    output logic [15:0]                       m_minor_version,
    output logic [15:0]                       m_message_kind,
    output logic [15:0]                       m_header_flags,
    output logic [63:0]                       m_request_number,
    output logic [63:0]                       m_payload_length,
    output logic [63:0]                       m_payload_sum,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fhc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                       cfg_data
);

    `include "frame_header_checker_top_assert.svh"

    // Configuration registers
    logic [31:0] expected_magic_reg;
    logic [15:0] required_major_reg;
    logic [15:0] newest_minor_reg;
    logic [63:0] payload_limit_reg;

    // Assembly state
    logic [fhc_pkg::COUNT_W-1:0]  count_reg;
    logic [fhc_pkg::COUNT_W-1:0]  count_next;
    logic [fhc_pkg::HEADER_W-1:0] hdr_reg;
    logic [fhc_pkg::HEADER_W-1:0] hdr_next;

    // Snapshot stage
    logic                         snap_valid_reg;
    logic [fhc_pkg::COUNT_W-1:0]  snap_count_reg;
    logic [fhc_pkg::HEADER_W-1:0] snap_hdr_reg;

    // Result stage
    logic        m_valid_reg;
    logic [2:0]  err_reg,   err_next;
    logic [15:0] major_reg, major_next;
    logic [15:0] minor_reg, minor_next;
    logic [15:0] kind_reg,  kind_next;
    logic [15:0] flags_reg, flags_next;
    logic [63:0] req_reg,   req_next;
    logic [63:0] size_reg,  size_next;
    logic [63:0] sum_reg,   sum_next;

    // Decoded words of the snapshot
    logic [31:0] f_magic;
    logic [15:0] f_major;
    logic [15:0] f_minor;
    logic [15:0] f_kind;
    logic [15:0] f_flags;
    logic [31:0] f_reserved;
    logic [63:0] f_request;
    logic [63:0] f_size;
    logic [63:0] f_sum;

    logic out_ready;
    logic in_xfer;

    // Flow control: result register frees the snapshot, snapshot frees input
    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !snap_valid_reg || out_ready;
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_magic_reg <= fhc_pkg::MAGIC_RESET;
            required_major_reg <= fhc_pkg::MAJOR_RESET;
            newest_minor_reg   <= fhc_pkg::MINOR_RESET;
            payload_limit_reg  <= fhc_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fhc_pkg::REG_EXPECTED_MAGIC: expected_magic_reg <= cfg_data[31:0];
                fhc_pkg::REG_REQUIRED_MAJOR: required_major_reg <= cfg_data[15:0];
                fhc_pkg::REG_NEWEST_MINOR:   newest_minor_reg   <= cfg_data[15:0];
                fhc_pkg::REG_PAYLOAD_LIMIT:  payload_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Byte insert and saturating count
    always_comb begin
        hdr_next = hdr_reg;
        for (int i = 0; i < fhc_pkg::HEADER_BYTES; i++) begin
            if (count_reg == fhc_pkg::COUNT_W'(i)) begin
                hdr_next[i*8 +: 8] = s_data_byte;
            end
        end
        if (count_reg == fhc_pkg::COUNT_MAX) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + fhc_pkg::COUNT_W'(1);
        end
    end

    // Header bytes are all rewritten by any buffer of the right length,
    // so the assembly register needs neither reset nor clearing.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            hdr_reg <= hdr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_xfer) begin
            count_reg <= s_final_byte ? '0 : count_next;
        end
    end

    // Snapshot of a finished buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (s_ready) begin
            snap_valid_reg <= in_xfer && s_final_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_final_byte) begin
            snap_hdr_reg   <= hdr_next;
            snap_count_reg <= count_next;
        end
    end

    // Field extraction, little-endian byte order
    assign f_magic    = snap_hdr_reg[31:0];
    assign f_major    = snap_hdr_reg[47:32];
    assign f_minor    = snap_hdr_reg[63:48];
    assign f_kind     = snap_hdr_reg[79:64];
    assign f_flags    = snap_hdr_reg[95:80];
    assign f_reserved = snap_hdr_reg[127:96];
    assign f_request  = snap_hdr_reg[191:128];
    assign f_size     = snap_hdr_reg[255:192];
    assign f_sum      = snap_hdr_reg[319:256];

    // Checks in priority order; fields past the failing check read zero
    always_comb begin
        err_next   = fhc_pkg::ERR_OK;
        major_next = '0;
        minor_next = '0;
        kind_next  = '0;
        flags_next = '0;
        req_next   = '0;
        size_next  = '0;
        sum_next   = '0;
        if (snap_count_reg != fhc_pkg::COUNT_FULL) begin
            err_next = fhc_pkg::ERR_BAD_LENGTH;
        end else if (f_magic != expected_magic_reg) begin
            err_next = fhc_pkg::ERR_BAD_MAGIC;
        end else if (f_major != required_major_reg || f_minor > newest_minor_reg) begin
            err_next   = fhc_pkg::ERR_VERSION;
            major_next = f_major;
            minor_next = f_minor;
        end else if (f_reserved != 32'd0) begin
            err_next   = fhc_pkg::ERR_RESERVED;
            major_next = f_major;
            minor_next = f_minor;
            kind_next  = f_kind;
            flags_next = f_flags;
        end else begin
            err_next   = (f_size > payload_limit_reg) ? fhc_pkg::ERR_TOO_LARGE
                                                      : fhc_pkg::ERR_OK;
            major_next = f_major;
            minor_next = f_minor;
            kind_next  = f_kind;
            flags_next = f_flags;
            req_next   = f_request;
            size_next  = f_size;
            sum_next   = f_sum;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && snap_valid_reg) begin
            err_reg   <= err_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
            kind_reg  <= kind_next;
            flags_reg <= flags_next;
            req_reg   <= req_next;
            size_reg  <= size_next;
            sum_reg   <= sum_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_error_code     = err_reg;
    assign m_major_version  = major_reg;
    assign m_minor_version  = minor_reg;
    assign m_message_kind   = kind_reg;
    assign m_header_flags   = flags_reg;
    assign m_request_number = req_reg;
    assign m_payload_length = size_reg;
    assign m_payload_sum    = sum_reg;

    // Checks
    `FHC_ASSERT_NEXT(a_count_step, aclk, aresetn,
        in_xfer && !s_final_byte && count_reg != fhc_pkg::COUNT_MAX,
        count_reg == $past(count_reg) + fhc_pkg::COUNT_W'(1))
    `FHC_ASSERT_NEXT(a_final_snap, aclk, aresetn, in_xfer && s_final_byte,
        snap_valid_reg && count_reg == '0)
    `FHC_ASSERT_SAME(a_len_zero, aclk, aresetn,
        m_valid_reg && err_reg == fhc_pkg::ERR_BAD_LENGTH,
        major_reg == '0 && req_reg == '0 && sum_reg == '0)

endmodule
